/* rtl/core/bpa_pkg.sv */
// shared constants of the buddy page allocator
`timescale 1ns / 1ps
package bpa_pkg;
  localparam int unsigned PagesDef    = 16384;
  localparam int unsigned MaxOrderDef = 10;
  localparam int unsigned PageShift   = 12;
  localparam logic [31:0] PageBaseRst = 32'h0010_0000;
  localparam logic        FuncAlloc   = 1'b0;
  localparam logic        FuncFree    = 1'b1;
endpackage

/* rtl/core/bpa_if.sv */
// valid/ready channel interfaces of the buddy page allocator
`timescale 1ns / 1ps
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [11:0] num_pages;
  logic [31:0] block_address;
  logic [3:0]  block_order;
  modport source (output valid, func, num_pages, block_address, block_order, input ready);
  modport sink   (input valid, func, num_pages, block_address, block_order, output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] address;
  logic [3:0]  order;
  modport source (output valid, ok, address, order, input ready);
  modport sink   (input valid, ok, address, order, output ready);
endinterface

interface bpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/bpa_ram.sv */
// generic single port ram with registered read
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

/* rtl/core/buddy_page_allocator.sv */
// buddy page allocator top level
`timescale 1ns / 1ps
// channel | dir | word
// req     | in  | func, num_pages, block_address, block_order
// rsp     | out | ok, address, order
// cfg     | in  | page_base
// one request at a time; an alloc unlinks a free block and splits it down as needed, a free
// checks its own tag and then merges with its free buddy for as long as it can.
// after reset a clearing pass writes every page entry, one per cycle, then the initial
// layout puts each block on its free list; no request is taken meanwhile.
// a finished word waits in the output register; the next request waits for it to leave.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int unsigned PAGES     = PagesDef,
  parameter int unsigned MAX_ORDER = MaxOrderDef
) (
  input logic clk_i,
  input logic rst_ni,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);
  localparam int unsigned PW = $clog2(PAGES) + 1; // page code incl. nil
  localparam int unsigned AW = $clog2(PAGES);
  localparam int unsigned OW = 4;
  localparam int unsigned NL = MAX_ORDER + 1;
  localparam int unsigned MW = 2 * PW + 5;
  localparam logic [PW-1:0] Nil = PW'(PAGES);

  typedef enum logic [12:0] {
    SInit  = 13'h0001, SIdle = 13'h0002, SAlloc = 13'h0004, STake = 13'h0008,
    SFix   = 13'h0010, SPut  = 13'h0020, SPutT = 13'h0040, SFree = 13'h0080,
    SBud   = 13'h0100, SBudR = 13'h0200, SDone = 13'h0400, SRd   = 13'h0800,
    SWait  = 13'h1000
  } state_e;

  // memory entry: next, prev, tag
  typedef struct packed {
    logic [PW-1:0] nxt;
    logic [PW-1:0] prv;
    logic          free;
    logic [3:0]    ord;
  } ent_t;

  state_e state_q, ret_q;
  logic [PW-1:0] head_q [NL];
  logic [PW-1:0] tail_q [NL];
  logic [31:0] base_q;
  logic func_q;
  logic [OW-1:0] want_q, o_q;
  logic [PW-1:0] p_q, b_q, x_q;
  logic [1:0] sub_q;
  ent_t e_q;
  logic [AW:0] ia_q;
  logic [PW:0] lt_q, ls_q;
  logic [OW-1:0] lk_q;
  logic lfix_q;
  logic out_v_q, out_ok_q;
  logic [31:0] out_a_q;
  logic [OW-1:0] out_o_q;

  logic we;
  logic [AW-1:0] ma;
  ent_t wd, rd;

  bpa_ram #(.Width(MW), .Depth(PAGES)) u_mem (
    .clk_i, .we_i(we), .addr_i(ma), .wdata_i(wd), .rdata_o(rd)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == SIdle) && !out_v_q;
  assign rsp.valid = out_v_q;
  assign rsp.ok = out_ok_q;
  assign rsp.address = out_a_q;
  assign rsp.order = out_o_q;

  // free checks and the order that an alloc wants
  logic [31:0] off;
  logic [31:0] fpg;
  logic bad_free;
  logic [OW-1:0] want_c;
  always_comb begin
    off = req.block_address - base_q;
    fpg = {12'd0, off[31:12]};
    bad_free = (off[11:0] != 12'd0) || (32'(req.block_order) > MAX_ORDER)
      || (fpg >= PAGES)
      || ((fpg & ((32'd1 << req.block_order) - 32'd1)) != 32'd0)
      || ((33'(fpg) + (33'd1 << req.block_order)) > 33'(PAGES));
    want_c = '0;
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if ((32'd1 << k) >= 32'(req.num_pages)) want_c = OW'(k);
    end
  end

  // first non-empty list at or above want
  logic [OW-1:0] found;
  logic hit;
  always_comb begin
    found = '0;
    hit = 1'b0;
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if (OW'(k) >= want_q && tail_q[k] != Nil) begin
        found = OW'(k);
        hit = 1'b1;
      end
    end
  end

  // layout: next block after lt_q of order lk_q
  logic [PW:0] lsz;
  assign lsz = (PW+1)'(1) << lk_q;

  always_comb begin
    we = 1'b0;
    ma = p_q[AW-1:0];
    wd = e_q;
    case (state_q)
      SInit: begin
        we = 1'b1;
        ma = ia_q[AW-1:0];
        wd = '{nxt: Nil, prv: Nil, free: 1'b0, ord: '0};
      end
      SRd: ma = x_q[AW-1:0];
      SFix: begin
        we = (sub_q != 2'd0) && ia_q[0];
        ma = x_q[AW-1:0];
        wd = rd;
        if (sub_q == 2'd1) wd.nxt = e_q.nxt; else wd.prv = e_q.prv;
      end
      SPut: begin
        we = 1'b1;
        ma = p_q[AW-1:0];
        wd = '{nxt: Nil, prv: tail_q[o_q], free: 1'b1, ord: o_q};
      end
      SPutT: begin
        we = (sub_q == 2'd1);
        ma = x_q[AW-1:0];
        wd = rd;
        wd.nxt = p_q;
      end
      STake: begin
        we = 1'b1;
        ma = x_q[AW-1:0];
        wd = '{nxt: Nil, prv: Nil, free: 1'b0, ord: '0};
      end
      SBudR: ma = b_q[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      ret_q <= SIdle;
      for (int k = 0; k < NL; k++) begin
        head_q[k] <= Nil;
        tail_q[k] <= Nil;
      end
      base_q <= PageBaseRst;
      ia_q <= '0;
      lt_q <= '0;
      lk_q <= '0;
      ls_q <= '0;
      lfix_q <= 1'b1;
      out_v_q <= 1'b0;
      sub_q <= '0;
    end else begin
      if (cfg.valid) base_q <= cfg.data;
      if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
      case (state_q)
        SInit: begin
          if (ia_q == (AW+1)'(PAGES - 1)) begin
            ia_q <= '0;
            state_q <= SDone;
            ls_q <= '0;
          end else begin
            ia_q <= ia_q + 1'b1;
          end
        end
        SDone: begin
          // pick next layout block (also return point of put during layout)
          if (lfix_q) begin
            // fixed part: step 0:p0/o0, 1:p1/o0, k+1: p 2^k / o k
            if (ls_q > (PW+1)'(MAX_ORDER + 1)) begin
              lfix_q <= 1'b0;
              lt_q <= (PW+1)'(1) << (MAX_ORDER + 1);
              lk_q <= OW'(MAX_ORDER);
            end else begin
              ls_q <= ls_q + 1'b1;
              if (ls_q < 2) begin
                p_q <= PW'(ls_q); o_q <= '0;
              end else begin
                p_q <= PW'((PW+1)'(1) << (ls_q - 1)); o_q <= OW'(ls_q - 1);
              end
              if (ls_q < 2 || ((PW+1)'(1) << (ls_q - 1)) + ((PW+1)'(1) << (ls_q - 1))
                  <= (PW+1)'(PAGES)) begin
                ret_q <= SDone;
                state_q <= SPut;
              end
            end
          end else begin
            if (lt_q + lsz < (PW+1)'(PAGES)) begin
              p_q <= PW'(lt_q); o_q <= lk_q;
              lt_q <= lt_q + lsz;
              ret_q <= SDone;
              state_q <= SPut;
            end else if (lk_q == '0) begin
              state_q <= SIdle;
            end else begin
              lk_q <= lk_q - 1'b1;
            end
          end
        end
        SIdle: if (req.valid && !out_v_q) begin
          func_q <= req.func;
          out_ok_q <= 1'b0;
          out_a_q <= '0;
          out_o_q <= '0;
          if (req.func == FuncAlloc) begin
            want_q <= want_c;
            if (req.num_pages == 12'd0 || 32'(req.num_pages) > (32'd1 << MAX_ORDER)) begin
              out_v_q <= 1'b1;
            end else begin
              state_q <= SAlloc;
            end
          end else if (bad_free) begin
            out_v_q <= 1'b1;
          end else begin
            p_q <= PW'(fpg);
            o_q <= req.block_order;
            state_q <= SFree;
            sub_q <= '0;
          end
        end
        SAlloc: begin
          if (!hit) begin
            out_v_q <= 1'b1;
            state_q <= SIdle;
          end else begin
            o_q <= found;
            p_q <= tail_q[found];
            x_q <= tail_q[found];
            ret_q <= SAlloc;
            sub_q <= '0;
            state_q <= SRd;
          end
        end
        SRd: begin
          state_q <= SWait;
        end
        SWait: begin
          // rd holds entry of x_q; start unlink
          e_q <= rd;
          if (rd.prv == Nil) head_q[o_q] <= rd.nxt;
          if (rd.nxt == Nil) tail_q[o_q] <= rd.prv;
          if (rd.prv != Nil) begin
            x_q <= rd.prv; sub_q <= 2'd1; state_q <= SFix;
          end else if (rd.nxt != Nil) begin
            x_q <= rd.nxt; sub_q <= 2'd2; state_q <= SFix;
          end else begin
            state_q <= STake;
          end
          b_q <= x_q;
        end
        SFix: begin
          // sub 1/2 writes are issued after a read, in two phases: read, then write;
          // the phase is encoded in ia_q[0]
          if (!ia_q[0]) begin
            ia_q[0] <= 1'b1; // wait for read data; no write this cycle
          end else begin
            ia_q[0] <= 1'b0;
            if (sub_q == 2'd1 && e_q.nxt != Nil) begin
              x_q <= e_q.nxt; sub_q <= 2'd2;
            end else begin
              x_q <= b_q; state_q <= STake;
            end
          end
        end
        STake: begin
          if (ret_q == SAlloc) begin
            if (o_q > want_q) begin
              o_q <= o_q - 1'b1;
              b_q <= p_q;
              p_q <= p_q + (PW'(1) << (o_q - 1'b1));
              ret_q <= SBud; // alloc split marker
              state_q <= SPut;
            end else begin
              out_v_q <= 1'b1; out_ok_q <= 1'b1;
              out_a_q <= base_q + (32'(p_q) << PageShift);
              out_o_q <= want_q;
              state_q <= SIdle;
            end
          end else begin
            // free merge: lower page wins
            if (b_q < p_q) p_q <= b_q;
            o_q <= o_q + 1'b1;
            state_q <= SFree;
            sub_q <= 2'd1;
          end
        end
        SPut: begin
          x_q <= tail_q[o_q];
          if (tail_q[o_q] == Nil) head_q[o_q] <= p_q;
          tail_q[o_q] <= p_q;
          sub_q <= (tail_q[o_q] == Nil) ? 2'd0 : 2'd2;
          state_q <= SPutT;
        end
        SPutT: begin
          if (sub_q == 2'd2) begin
            sub_q <= 2'd1; // read issued, write next cycle
          end else begin
            if (ret_q == SBud) begin
              if (o_q > want_q) begin
                o_q <= o_q - 1'b1;
                p_q <= b_q + (PW'(1) << (o_q - 1'b1));
                state_q <= SPut;
              end else begin
                out_v_q <= 1'b1; out_ok_q <= 1'b1;
                out_a_q <= base_q + (32'(b_q) << PageShift);
                out_o_q <= want_q;
                state_q <= SIdle;
              end
            end else if (ret_q == SFree) begin
              out_v_q <= 1'b1; out_ok_q <= 1'b1;
              state_q <= SIdle;
            end else begin
              state_q <= ret_q;
            end
          end
        end
        SFree: begin
          // sub 0: check own tag; sub 1: look at buddy
          if (sub_q == 2'd0) begin
            x_q <= p_q; b_q <= p_q; sub_q <= 2'd3; state_q <= SBudR;
          end else if (32'(o_q) >= MAX_ORDER
              || 32'(p_q ^ (PW'(1) << o_q)) >= PAGES) begin
            ret_q <= SFree; state_q <= SPut;
          end else begin
            b_q <= p_q ^ (PW'(1) << o_q);
            sub_q <= 2'd2;
            state_q <= SBudR;
          end
        end
        SBudR: begin
          state_q <= SBud;
        end
        SBud: begin
          if (sub_q == 2'd3) begin
            if (rd.free) begin
              out_v_q <= 1'b1; state_q <= SIdle;
            end else begin
              sub_q <= 2'd1; state_q <= SFree;
            end
          end else if (rd.free && rd.ord == o_q) begin
            e_q <= rd;
            ret_q <= SFree;
            if (rd.prv == Nil) head_q[o_q] <= rd.nxt;
            if (rd.nxt == Nil) tail_q[o_q] <= rd.prv;
            if (rd.prv != Nil) begin
              x_q <= rd.prv; sub_q <= 2'd1; state_q <= SFix;
            end else if (rd.nxt != Nil) begin
              x_q <= rd.nxt; sub_q <= 2'd2; state_q <= SFix;
            end else begin
              x_q <= b_q; state_q <= STake;
            end
          end else begin
            ret_q <= SFree; state_q <= SPut;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken twice");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SInit) |-> !req.ready)
    else $error("ready during layout");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_ok_q && func_q == FuncAlloc) |-> (32'(out_o_q) <= MAX_ORDER))
    else $error("bad order out");
endmodule

/* tb/tb_buddy_page_allocator.sv */
// self-checking testbench of the buddy page allocator with its own free-list predictor
`timescale 1ns / 1ps
module tb_buddy_page_allocator;
  import bpa_pkg::*;

  localparam int unsigned NPages  = PagesDef;
  localparam int unsigned TopOrd  = MaxOrderDef;
  localparam int unsigned NoPage  = NPages;
  localparam logic [4:0]  FreeTag = 5'h10;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [3:0]  order;
  } alloc_word_t;

  typedef struct {
    int unsigned page;
    int unsigned ord;
  } held_block_t;

  logic clk_i;
  logic rst_ni;

  bpa_req_if req_ch ();
  bpa_rsp_if rsp_ch ();
  bpa_cfg_if cfg_ch ();

  buddy_page_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  logic [31:0] base_q;
  int unsigned head_q [TopOrd+1];
  int unsigned tail_q [TopOrd+1];
  int unsigned nxt_q  [NPages];
  int unsigned prv_q  [NPages];
  logic [4:0]  tag_q  [NPages];

  alloc_word_t  pending_words [$];
  held_block_t  held [$];
  alloc_word_t  pending_dummy;
  int           mismatches;
  int           send_idle_pct;
  int           recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void list_append(int unsigned p, int unsigned o);
    int unsigned t;
    t = tail_q[o];
    nxt_q[p] = NoPage;
    prv_q[p] = t;
    if (t == NoPage) head_q[o] = p;
    else nxt_q[t] = p;
    tail_q[o] = p;
    tag_q[p] = FreeTag | 5'(o);
  endfunction

  function automatic void list_unlink(int unsigned p, int unsigned o);
    int unsigned n;
    int unsigned v;
    n = nxt_q[p];
    v = prv_q[p];
    if (v == NoPage) head_q[o] = n;
    else nxt_q[v] = n;
    if (n == NoPage) tail_q[o] = v;
    else prv_q[n] = v;
    nxt_q[p] = NoPage;
    prv_q[p] = NoPage;
    tag_q[p] = '0;
  endfunction

  function automatic void load_layout();
    longint unsigned t;
    longint unsigned s;
    base_q = PageBaseRst;
    for (int k = 0; k <= TopOrd; k++) begin
      head_q[k] = NoPage;
      tail_q[k] = NoPage;
    end
    for (int i = 0; i < NPages; i++) begin
      nxt_q[i] = NoPage;
      prv_q[i] = NoPage;
      tag_q[i] = '0;
    end
    list_append(0, 0);
    list_append(1, 0);
    for (int k = 1; k <= TopOrd; k++) begin
      if ((1 << k) + (1 << k) <= NPages) list_append(1 << k, k);
    end
    t = 64'd1 << (TopOrd + 1);
    for (int k = TopOrd; k >= 0; k--) begin
      s = 64'd1 << k;
      while (t + s < NPages) begin
        list_append(int'(t), k);
        t += s;
      end
    end
  endfunction

  function automatic alloc_word_t predict_word(logic func, logic [11:0] cnt,
                                               logic [31:0] addr, logic [3:0] ordi);
    alloc_word_t w;
    int unsigned want;
    int unsigned o;
    int unsigned p;
    int unsigned b;
    logic [31:0] off;
    w = '0;
    if (func == FuncAlloc) begin
      if (cnt == 0 || cnt > (1 << TopOrd)) return w;
      want = 0;
      while ((1 << want) < cnt) want++;
      o = want;
      while (o <= TopOrd && tail_q[o] == NoPage) o++;
      if (o > TopOrd) return w;
      p = tail_q[o];
      list_unlink(p, o);
      while (o > want) begin
        o--;
        list_append(p + (1 << o), o);
      end
      w.ok = 1'b1;
      w.address = base_q + (32'(p) << PageShift);
      w.order = 4'(want);
    end else begin
      off = addr - base_q;
      p = off >> PageShift;
      o = ordi;
      if (off[11:0] != 0 || o > TopOrd || p >= NPages) return w;
      if ((p & ((1 << o) - 1)) != 0) return w;
      if (p + (1 << o) > NPages) return w;
      if (tag_q[p][4]) return w;
      while (o < TopOrd) begin
        b = p ^ (1 << o);
        if (b >= NPages || tag_q[b] != (FreeTag | 5'(o))) break;
        list_unlink(b, o);
        if (b < p) p = b;
        o++;
      end
      list_append(p, o);
      w.ok = 1'b1;
    end
    return w;
  endfunction

  task automatic send_request(logic func, logic [11:0] cnt, logic [31:0] addr,
                              logic [3:0] ordi, output alloc_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    req_ch.func = func;
    req_ch.num_pages = cnt;
    req_ch.block_address = addr;
    req_ch.block_order = ordi;
    do @(posedge clk_i); while (!req_ch.ready);
    w = predict_word(func, cnt, addr, ordi);
    pending_words.push_back(w);
    @(negedge clk_i);
    req_ch.valid = 1'b0;
  endtask

  task automatic alloc_pages(logic [11:0] cnt);
    alloc_word_t w;
    held_block_t hb;
    send_request(FuncAlloc, cnt, $urandom, 4'($urandom), w);
    if (w.ok) begin
      hb.page = (w.address - base_q) >> PageShift;
      hb.ord = w.order;
      held.push_back(hb);
    end
  endtask

  task automatic free_block(logic [31:0] addr, logic [3:0] ordi);
    alloc_word_t w;
    send_request(FuncFree, 12'($urandom), addr, ordi, w);
  endtask

  task automatic free_held(int idx, bit again);
    held_block_t hb;
    hb = held[idx];
    held.delete(idx);
    free_block(base_q + (32'(hb.page) << PageShift), 4'(hb.ord));
    if (again) free_block(base_q + (32'(hb.page) << PageShift), 4'(hb.ord));
  endtask

  task automatic drain_words();
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_page_base(logic [31:0] value);
    drain_words();
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    base_q = value;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // response side: random stall and in-order compare
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    alloc_word_t exp_w;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word ok=%0b addr=%h ord=%0d",
                                       rsp_ch.ok, rsp_ch.address, rsp_ch.order);
      end else begin
        exp_w = pending_words.pop_front();
        if (rsp_ch.ok !== exp_w.ok || rsp_ch.address !== exp_w.address ||
            rsp_ch.order !== exp_w.order) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok=%0b addr=%h ord=%0d, got ok=%0b addr=%h ord=%0d",
                     exp_w.ok, exp_w.address, exp_w.order,
                     rsp_ch.ok, rsp_ch.address, rsp_ch.order);
        end
      end
    end
  end

  task automatic test_directed_edges();
    alloc_pages(12'd0);
    alloc_pages(12'd4095);
    alloc_pages(12'd1025);
    alloc_pages(12'd1);
    alloc_pages(12'd2);
    alloc_pages(12'd3);
    alloc_pages(12'd1024);
    // rejected frees: misaligned offset, order too big, page out of range, unaligned page
    free_block(base_q + 32'h0000_0800, 4'd0);
    free_block(base_q, 4'd11);
    free_block(base_q, 4'd15);
    free_block(base_q + (32'(NPages) << PageShift), 4'd0);
    free_block(base_q + 32'h0000_3000, 4'd1);
    free_block(base_q - 32'h0000_1000, 4'd0);
    // double free of a page that is already free
    free_block(base_q + 32'h0000_4000, 4'd2);
    while (held.size() != 0) free_held(held.size() - 1, 1'b0);
  endtask

  task automatic test_exhaustion();
    for (int i = 0; i < 16; i++) alloc_pages(12'd1024);
    while (held.size() != 0) free_held($urandom_range(0, held.size() - 1), 1'b0);
  endtask

  task automatic test_random_mix(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise over every field
        send_request(1'($urandom), 12'($urandom), $urandom, 4'($urandom), pending_dummy);
      end else if (r < 52 && held.size() != 0) begin
        free_held($urandom_range(0, held.size() - 1), $urandom_range(0, 19) == 0);
      end else if (r < 56) begin
        alloc_pages(12'($urandom_range(17, 1024)));
      end else begin
        alloc_pages(12'($urandom_range(1, 16)));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func = FuncAlloc;
    req_ch.num_pages = '0;
    req_ch.block_address = '0;
    req_ch.block_order = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    mismatches = 0;
    send_idle_pct = 8;
    recv_idle_pct = 49;
    load_layout();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_edges();
    test_exhaustion();
    test_random_mix(400);
    write_page_base(32'h0000_0000);
    send_idle_pct = 49;
    recv_idle_pct = 8;
    test_random_mix(400);
    write_page_base(32'hFFFF_F000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(200);
    write_page_base($urandom);
    test_random_mix(200);

    drain_words();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* buddy_page_allocator.f */
rtl/core/bpa_pkg.sv
rtl/core/bpa_if.sv
rtl/core/bpa_ram.sv
rtl/core/buddy_page_allocator.sv
tb/tb_buddy_page_allocator.sv
